FILE: rtl/swsr_pkg.sv
package swsr_pkg;

	localparam int SCALAR_BYTES = 32;
	localparam int SCALAR_BITS  = 256;

	localparam int BYTE_W  = 8;
	localparam int WIN_W   = 4;
	localparam int DIGIT_W = 11;
	localparam int INDEX_W = 6;
	localparam int BUF_W   = 32;
	localparam int HELD_W  = 9;
	localparam int CNT_W   = $clog2(SCALAR_BYTES) + 1;
	localparam int NDIG_W  = INDEX_W + 1;
	localparam int NRES_W  = 2;
	localparam int VAL_W   = DIGIT_W + 1;

	localparam logic [WIN_W-1:0]  WIN_MIN   = WIN_W'(4);
	localparam logic [WIN_W-1:0]  WIN_MAX   = WIN_W'(11);
	localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(4);
	localparam logic [NRES_W-1:0] MAX_RES   = NRES_W'(3);
	localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(SCALAR_BYTES);

	// per-scalar recoder state
	typedef struct packed {
		logic [BUF_W-1:0]   bits;
		logic [HELD_W-1:0]  held;
		logic               carry;
		logic [CNT_W-1:0]   cnt;
		logic [INDEX_W-1:0] idx;
	} st_t;

	// clamp window to the supported range
	function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] r;
		r = w;
		if (w < WIN_MIN) r = WIN_MIN;
		if (w > WIN_MAX) r = WIN_MAX;
		return r;
	endfunction

	// digits per scalar: ceil(SCALAR_BITS / w)
	function automatic logic [NDIG_W-1:0] digits_per_scalar(input logic [WIN_W-1:0] w);
		logic [NDIG_W-1:0] n;
		unique case (w)
			WIN_W'(4):  n = NDIG_W'((SCALAR_BITS + 3) / 4);
			WIN_W'(5):  n = NDIG_W'((SCALAR_BITS + 4) / 5);
			WIN_W'(6):  n = NDIG_W'((SCALAR_BITS + 5) / 6);
			WIN_W'(7):  n = NDIG_W'((SCALAR_BITS + 6) / 7);
			WIN_W'(8):  n = NDIG_W'((SCALAR_BITS + 7) / 8);
			WIN_W'(9):  n = NDIG_W'((SCALAR_BITS + 8) / 9);
			WIN_W'(10): n = NDIG_W'((SCALAR_BITS + 9) / 10);
			default:    n = NDIG_W'((SCALAR_BITS + 10) / 11);
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/swsr_digit.sv
// One signed-window digit step: low w bits plus carry, recentred.
module swsr_digit (
	input  logic [swsr_pkg::BUF_W-1:0]   bits,
	input  logic                         carry_in,
	input  logic [swsr_pkg::WIN_W-1:0]   win,
	output logic [swsr_pkg::DIGIT_W-1:0] digit,
	output logic                         carry_out,
	output logic [swsr_pkg::BUF_W-1:0]   bits_rest
);

	logic [swsr_pkg::VAL_W-1:0] radix;
	logic [swsr_pkg::VAL_W-1:0] half;
	logic [swsr_pkg::VAL_W-1:0] chunk;
	logic [swsr_pkg::VAL_W-1:0] val;
	logic [swsr_pkg::VAL_W-1:0] wrapped;

	always_comb begin
		radix     = swsr_pkg::VAL_W'(1) << win;
		half      = radix >> 1;
		chunk     = bits[swsr_pkg::VAL_W-1:0] & (radix - swsr_pkg::VAL_W'(1));
		val       = chunk + swsr_pkg::VAL_W'(carry_in);
		wrapped   = val - radix;
		carry_out = (val >= half);
		digit     = carry_out ? wrapped[swsr_pkg::DIGIT_W-1:0] : val[swsr_pkg::DIGIT_W-1:0];
		bits_rest = bits >> win;
	end

endmodule

FILE: rtl/signed_window_scalar_recoder_unit.sv
// Signed-window scalar recoder. Scalar bytes arrive least significant first on
// the s_ stream; each 256-bit scalar (32 beats) is recoded into ceil(256/w)
// signed radix-2^w digits, lowest first, on the m_ stream, the top digit
// flagged by m_tlast and carrying the final carry unreduced. The window w is
// set by cfg_wr_data (4..11, out-of-range values clamp; reset value 4) and
// should only be written between beats. Timing: one input register, one
// digit step per cycle through the state registers, one output register.
// Each step yields at most one digit, so one result beat per cycle is the
// ceiling. The step after a byte merges its insertion with the first digit,
// and a lookahead frees the state registers with the last digit of a byte,
// so the next byte is taken by the very next step, with no idle step. While
// a result waits for m_tready the state stalls and only the input register
// can still take one beat. A byte's first digit passes the input register
// and then the output register, where m_tvalid rises.
module signed_window_scalar_recoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// window width register
	input  logic                               cfg_wr_en,
	input  logic [swsr_pkg::WIN_W-1:0]         cfg_wr_data,
	// scalar byte stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] scalar_byte
	// digit stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // [10:0] digit, [16:11] digit_index
	output logic                               m_tlast    // last_digit
);

	// config
	logic [swsr_pkg::WIN_W-1:0]   win_q;
	logic [swsr_pkg::WIN_W-1:0]   win;
	logic [swsr_pkg::NDIG_W-1:0]  ndig;

	// input register
	logic                         in_vld_s1;
	logic [swsr_pkg::BYTE_W-1:0]  in_byte_s1;

	// recoder state
	swsr_pkg::st_t                st_q;
	logic                         busy_q;     // byte inserted, digits still due
	logic [swsr_pkg::NRES_W-1:0]  nres_q;     // digits sent for current byte

	// output register
	logic                         out_vld_q;
	logic [swsr_pkg::DIGIT_W-1:0] out_digit_q;
	logic [swsr_pkg::INDEX_W-1:0] out_idx_q;
	logic                         out_last_q;

	// step logic
	swsr_pkg::st_t                view;
	swsr_pkg::st_t                post;
	logic [swsr_pkg::NRES_W-1:0]  view_nres;
	logic [swsr_pkg::NRES_W-1:0]  post_nres;
	logic [swsr_pkg::BUF_W-1:0]   ins_bits;
	logic                         step_en;
	logic                         take;
	logic                         can_dig;
	logic                         can_top;
	logic                         more;
	logic [swsr_pkg::DIGIT_W-1:0] dig;
	logic                         dig_carry;
	logic [swsr_pkg::BUF_W-1:0]   dig_rest;
	logic [swsr_pkg::BUF_W-1:0]   top_sum;

	function automatic logic dig_ok(input swsr_pkg::st_t s,
			input logic [swsr_pkg::NRES_W-1:0] n,
			input logic [swsr_pkg::WIN_W-1:0] w,
			input logic [swsr_pkg::NDIG_W-1:0] nd);
		return (s.held >= swsr_pkg::HELD_W'(w)) &&
			((swsr_pkg::NDIG_W'(s.idx) + swsr_pkg::NDIG_W'(1)) < nd) &&
			(n < swsr_pkg::MAX_RES);
	endfunction

	function automatic logic top_ok(input swsr_pkg::st_t s,
			input logic [swsr_pkg::NRES_W-1:0] n);
		return (s.cnt >= swsr_pkg::LAST_CNT) && (n < swsr_pkg::MAX_RES);
	endfunction

	assign win  = swsr_pkg::eff_win(win_q);
	assign ndig = swsr_pkg::digits_per_scalar(win);

	swsr_digit u_digit (
		.bits      (view.bits),
		.carry_in  (view.carry),
		.win       (win),
		.digit     (dig),
		.carry_out (dig_carry),
		.bits_rest (dig_rest)
	);

	always_comb begin
		step_en  = (!out_vld_q || m_tready) && (busy_q || in_vld_s1);
		take     = step_en && !busy_q;
		ins_bits = swsr_pkg::BUF_W'(in_byte_s1) << st_q.held;

		// state as seen by this step: pending byte merged in when starting one
		view      = st_q;
		view_nres = nres_q;
		if (!busy_q) begin
			view.bits = st_q.bits | ins_bits;
			view.held = st_q.held + swsr_pkg::HELD_W'(swsr_pkg::BYTE_W);
			if (st_q.cnt < swsr_pkg::LAST_CNT) begin
				view.cnt = st_q.cnt + swsr_pkg::CNT_W'(1);
			end
			view_nres = '0;
		end

		can_dig = dig_ok(view, view_nres, win, ndig);
		can_top = top_ok(view, view_nres);
		top_sum = view.bits + swsr_pkg::BUF_W'(view.carry);

		post       = view;
		post.bits  = dig_rest;
		post.held  = view.held - swsr_pkg::HELD_W'(win);
		post.carry = dig_carry;
		post.idx   = view.idx + swsr_pkg::INDEX_W'(1);
		post_nres  = view_nres + swsr_pkg::NRES_W'(1);
		more       = dig_ok(post, post_nres, win, ndig) || top_ok(post, post_nres);
	end

	assign s_tready = !in_vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swsr_pkg::WIN_RESET;
		end else if (cfg_wr_en) begin
			win_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_vld_s1 <= 1'b1;
		end else if (take) begin
			in_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
		end
	end

	// recoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			busy_q <= 1'b0;
			nres_q <= '0;
		end else if (step_en) begin
			if (can_dig) begin
				st_q   <= post;
				busy_q <= more;
				nres_q <= post_nres;
			end else if (can_top) begin
				st_q   <= '0;
				busy_q <= 1'b0;
				nres_q <= '0;
			end else begin
				// byte yields nothing yet: keep its bits and wait for the next
				st_q   <= view;
				busy_q <= 1'b0;
				nres_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step_en && (can_dig || can_top)) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && (can_dig || can_top)) begin
			out_idx_q  <= view.idx;
			out_last_q <= !can_dig;
			out_digit_q <= can_dig ? dig : top_sum[swsr_pkg::DIGIT_W-1:0];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, out_idx_q, out_digit_q};
	assign m_tlast  = out_last_q;

endmodule
